### rtl/core/mf3_pkg.sv
// Shared constants and types of the 3x3 median filter.
package mf3_pkg;

   // Frame geometry limits and register field widths
   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 4096;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int RowW      = $clog2(MaxHeight);
   localparam int WidthW    = 11;
   localparam int HeightW   = 13;
   localparam int PixW      = 8;
   localparam int CsrW      = 32;
   localparam int CsrAddrW  = 3;

   localparam logic [WidthW-1:0]  WidthReset  = 11'd640;
   localparam logic [HeightW-1:0] HeightReset = 13'd480;
   localparam logic [WidthW-1:0]  WidthMin    = 11'd3;
   localparam logic [HeightW-1:0] HeightMin   = 13'd3;

   // Register map, selected by address bit 2
   typedef enum logic {
      RegFrameWidth  = 1'b0,
      RegFrameHeight = 1'b1
   } csr_reg_type;

   // Nine pixels of the window, slot 0 top left to slot 8 bottom right
   typedef logic [8:0][PixW-1:0] win_type;

endpackage

### rtl/core/mf3_sort9.sv
// Nine-input median by a fixed 19-exchange compare-swap network.
module mf3_sort9
   import mf3_pkg::*;
(
   input  win_type         win,
   output logic [PixW-1:0] median
);

   // Order one pair so that the first slot given holds the smaller value
   function automatic win_type cswap(win_type v, logic [3:0] a, logic [3:0] b);
      win_type r;
      r = v;
      if (v[a] > v[b]) begin
         r[a] = v[b];
         r[b] = v[a];
      end
      return r;
   endfunction

   win_type v;

   // Run the network layer by layer; pairs within a layer are independent
   always_comb begin
      v = win;
      // sort each row
      v = cswap(v, 4'd1, 4'd2);
      v = cswap(v, 4'd4, 4'd5);
      v = cswap(v, 4'd7, 4'd8);
      v = cswap(v, 4'd0, 4'd1);
      v = cswap(v, 4'd3, 4'd4);
      v = cswap(v, 4'd6, 4'd7);
      v = cswap(v, 4'd1, 4'd2);
      v = cswap(v, 4'd4, 4'd5);
      v = cswap(v, 4'd7, 4'd8);
      // merge across rows
      v = cswap(v, 4'd0, 4'd3);
      v = cswap(v, 4'd5, 4'd8);
      v = cswap(v, 4'd4, 4'd7);
      v = cswap(v, 4'd3, 4'd6);
      v = cswap(v, 4'd1, 4'd4);
      v = cswap(v, 4'd2, 4'd5);
      v = cswap(v, 4'd4, 4'd7);
      // settle the center
      v = cswap(v, 4'd4, 4'd2);
      v = cswap(v, 4'd6, 4'd4);
      v = cswap(v, 4'd4, 4'd2);
   end

   assign median = v[4];

endmodule

### rtl/core/median_filter_3x3.sv
// Streaming 3x3 median filter: line stores, window registers and result register.
//
// Pixels enter in raster order, one per clock at full rate; a pixel is taken in
// every cycle unless a finished result waits and the output side stalls. The
// line stores are single-port-read memories whose registered read feeds the
// window stage; the result register follows that stage. Only interior pixels
// (not in the first or last row or column) give a result; it carries the median,
// the row minus two and column minus one of the input, and a last-of-frame mark.
// frame_width (address 0) and frame_height (address 4) are clamped to 3..1024
// and 3..4096; writing either restarts the frame at row 0, column 0. The line
// stores need no clearing after reset: rows 0 and 1 of each frame fill every
// column before it is read for a result.
module median_filter_3x3
   import mf3_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [PixW-1:0]     req_pixel_in,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PixW-1:0]     rsp_median_value,
   output logic [RowW-1:0]     rsp_out_row,
   output logic [ColW-1:0]     rsp_out_col,
   output logic                rsp_frame_last,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrW-1:0]     csr_pwdata,
   output logic [CsrW-1:0]     csr_prdata,
   output logic                csr_pready
);

   // Registers
   logic [WidthW-1:0]  width_raw_ff;
   logic [HeightW-1:0] height_raw_ff;
   logic [WidthW-1:0]  width_eff;
   logic [HeightW-1:0] height_eff;
   logic               csr_write;
   csr_reg_type        csr_sel;

   // Position counters
   logic [ColW-1:0] col_ff;
   logic [RowW-1:0] row_ff;
   logic            at_row_end;
   logic            at_frame_end;
   logic            req_emit;

   // Line stores
   logic [PixW-1:0] upper_mem [MaxWidth];
   logic [PixW-1:0] middle_mem [MaxWidth];

   // Window stage
   logic            s1_valid_ff;
   logic [PixW-1:0] s1_pixel_ff;
   logic [PixW-1:0] s1_up_ff;
   logic [PixW-1:0] s1_mid_ff;
   logic [ColW-1:0] s1_col_ff;
   logic [RowW-1:0] s1_row_ff;
   logic            s1_emit_ff;
   logic            s1_last_ff;
   logic [PixW-1:0] win_ff [6];
   win_type         win;
   logic [PixW-1:0] median;

   // Flow control
   logic out_free;
   logic s1_free;
   logic accept;
   logic advance;

   // Result register
   logic            rsp_valid_ff;
   logic [PixW-1:0] rsp_median_ff;
   logic [RowW-1:0] rsp_row_ff;
   logic [ColW-1:0] rsp_col_ff;
   logic            rsp_last_ff;

   // Decode register access
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_sel)
         RegFrameWidth:  csr_prdata = CsrW'(width_raw_ff);
         RegFrameHeight: csr_prdata = CsrW'(height_raw_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Clamp geometry to the supported range
   always_comb begin
      if (width_raw_ff < WidthMin) begin
         width_eff = WidthMin;
      end else if (width_raw_ff > WidthW'(MaxWidth)) begin
         width_eff = WidthW'(MaxWidth);
      end else begin
         width_eff = width_raw_ff;
      end
      if (height_raw_ff < HeightMin) begin
         height_eff = HeightMin;
      end else if (height_raw_ff > HeightW'(MaxHeight)) begin
         height_eff = HeightW'(MaxHeight);
      end else begin
         height_eff = height_raw_ff;
      end
   end

   // Locate the incoming pixel in the frame
   assign at_row_end   = ({1'b0, col_ff} == width_eff - WidthW'(1));
   assign at_frame_end = at_row_end && ({1'b0, row_ff} == height_eff - HeightW'(1));
   assign req_emit     = (row_ff >= RowW'(2)) && (col_ff >= ColW'(2));

   // Hold the window stage while its result cannot be placed
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_free   = !s1_valid_ff || !s1_emit_ff || out_free;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;
   assign advance   = s1_valid_ff && s1_free;

   // Registers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= WidthReset;
         height_raw_ff <= HeightReset;
         col_ff        <= '0;
         row_ff        <= '0;
      end else if (csr_write) begin
         // restart the frame on any register write
         case (csr_sel)
            RegFrameWidth:  width_raw_ff  <= csr_pwdata[WidthW-1:0];
            RegFrameHeight: height_raw_ff <= csr_pwdata[HeightW-1:0];
            default:        width_raw_ff  <= width_raw_ff;
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (at_row_end) begin
            col_ff <= '0;
            row_ff <= at_frame_end ? '0 : row_ff + RowW'(1);
         end else begin
            col_ff <= col_ff + ColW'(1);
         end
      end
   end

   // Line stores: read both at the request, push the middle row up on advance
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_up_ff           <= upper_mem[col_ff];
         s1_mid_ff          <= middle_mem[col_ff];
         middle_mem[col_ff] <= req_pixel_in;
      end
      if (advance) begin
         upper_mem[s1_col_ff] <= s1_mid_ff;
      end
   end

   // Window stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel_in;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_emit_ff  <= req_emit;
         s1_last_ff  <= at_frame_end;
      end
   end

   // Window stage valid and column shift
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= s1_up_ff;
            win_ff[4] <= s1_mid_ff;
            win_ff[5] <= s1_pixel_ff;
         end
      end
   end

   // Assemble the 3x3 neighborhood, rows top to bottom
   always_comb begin
      win[0] = win_ff[0];
      win[1] = win_ff[3];
      win[2] = s1_up_ff;
      win[3] = win_ff[1];
      win[4] = win_ff[4];
      win[5] = s1_mid_ff;
      win[6] = win_ff[2];
      win[7] = win_ff[5];
      win[8] = s1_pixel_ff;
   end

   mf3_sort9 u_sort9 (
      .win    (win),
      .median (median)
   );

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (advance && s1_emit_ff) begin
         rsp_median_ff <= median;
         rsp_row_ff    <= s1_row_ff - RowW'(2);
         rsp_col_ff    <= s1_col_ff - ColW'(1);
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_median_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_frame_last   = rsp_last_ff;

`ifndef SYNTH
   // Column counter stays inside the row in use
   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < width_eff)
      else $error("column counter beyond frame width");

   // Row counter stays inside the frame in use
   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} < height_eff)
      else $error("row counter beyond frame height");

   // The last pixel of a row wraps the column counter
   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && at_row_end) |=> (col_ff == '0))
      else $error("column counter did not wrap");

   // A pending result that cannot move blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_emit_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while window stage is blocked");
`endif

endmodule
